// ===== src/shcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcs_pkg
// Types and constants shared by the command line syntax checker.
// ----------------------------------------------------------------------------
package shcs_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned PHASE_W = 4;

    // Parse phase codes
    localparam logic [PHASE_W-1:0] PH_EXPECT_CMD = 4'd0;  // start or after '|'
    localparam logic [PHASE_W-1:0] PH_IN_CMD     = 4'd1;  // inside or after a word
    localparam logic [PHASE_W-1:0] PH_AFTER_SEP  = 4'd2;  // after '&' or ';'
    localparam logic [PHASE_W-1:0] PH_AFTER_GT   = 4'd3;  // just after '>'
    localparam logic [PHASE_W-1:0] PH_EXPECT_TGT = 4'd4;  // redirect target due
    localparam logic [PHASE_W-1:0] PH_REJECTED   = 4'd5;  // sticky reject

    // Character codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_AMP   = 8'h26;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CH_W-1:0] CH_PIPE  = 8'h7C;

    // Outcome of one item applied to the current phase
    typedef struct packed {
        logic               is_end;      // item terminates the line
        logic               ok;          // verdict, meaningful on is_end
        logic [PHASE_W-1:0] next_phase;
    } step_t;

endpackage
`default_nettype wire

// ===== src/shcs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcs_if
// Valid/ready channels for character items in and verdict items out.
// ----------------------------------------------------------------------------
interface shcs_char_if;
    logic                       valid;
    logic                       ready;
    logic [shcs_pkg::CH_W-1:0]  ch;
    logic                       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface shcs_verdict_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, output accepted, input ready);
    modport sink   (input valid, input accepted, output ready);
endinterface
`default_nettype wire

// ===== src/shell_command_syntax_checker_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shell_command_syntax_checker_core
// Byte-serial command line syntax checker with registered in and out stages.
// ----------------------------------------------------------------------------
// One character item is taken every clock while input is not held off. Each
// item is captured in an input register, the parse phase is then advanced by a
// small state machine, and a terminator item (line_end set or byte 0) leaves
// its verdict in the result register, where it waits to be taken. Ordinary
// bytes give no result. Input is held off only when a terminator reaches the
// phase logic while the previous verdict is still waiting to be taken;
// otherwise the rate is one item per cycle.
module shell_command_syntax_checker_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    shcs_char_if.sink          cmd_in,
    shcs_verdict_if.source     verdict_out
);
    import shcs_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [CH_W-1:0]   in_ch_reg;
    logic              in_end_reg;

    // Parse state and result register
    logic [PHASE_W-1:0] phase_reg;
    logic              out_valid_reg;
    logic              out_acc_reg;

    step_t step;
    logic  advance;

    shcs_phase_logic u_phase (
        .phase    (phase_reg),
        .ch       (in_ch_reg),
        .line_end (in_end_reg),
        .step     (step)
    );

    // The held item moves on unless it is a verdict with nowhere to go
    assign advance = in_valid_reg &&
                     (!step.is_end || !out_valid_reg || verdict_out.ready);
    assign cmd_in.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd_in.ready)
            in_valid_reg <= cmd_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.ready && cmd_in.valid)
        begin
            in_ch_reg  <= cmd_in.ch;
            in_end_reg <= cmd_in.line_end;
        end
    end

    // Parse phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_EXPECT_CMD;
        else if (advance)
            phase_reg <= step.next_phase;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && step.is_end)
            out_valid_reg <= 1'b1;
        else if (verdict_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.is_end)
            out_acc_reg <= step.ok;
    end

    assign verdict_out.valid    = out_valid_reg;
    assign verdict_out.accepted = out_acc_reg;

`ifndef SYNTHESIS
    // A verdict only appears after a terminator has left the input register
    a_verdict_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && step.is_end))
        else $error("verdict without terminator");

    // A terminator restarts the parse
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step.is_end) |=> (phase_reg == PH_EXPECT_CMD))
        else $error("phase not restarted after terminator");

    // The input stage stalls only behind an untaken verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (out_valid_reg && !verdict_out.ready))
        else $error("input stage stalled without cause");
`endif

endmodule
`default_nettype wire

// ===== src/shcs_phase_logic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcs_phase_logic
// Character classification and next-phase / verdict logic for one item.
// ----------------------------------------------------------------------------
module shcs_phase_logic (
    input  wire logic [shcs_pkg::PHASE_W-1:0] phase,
    input  wire logic [shcs_pkg::CH_W-1:0]    ch,
    input  wire logic                         line_end,
    output shcs_pkg::step_t                   step
);
    import shcs_pkg::*;

    logic is_blank;
    logic is_word;
    logic [PHASE_W-1:0] nxt;

    // Classify the byte: blanks, word bytes, everything else is an operator
    // or a reject character
    always_comb
    begin
        is_blank = 1'b0;
        is_word  = 1'b0;
        case (ch)
            CH_SPACE, CH_TAB, CH_LF: is_blank = 1'b1;
            CH_NUL, CH_CR, CH_VT, CH_FF,
            CH_PIPE, CH_AMP, CH_GT, CH_LT, CH_SEMI: is_word = 1'b0;
            default: is_word = 1'b1;
        endcase
    end

    // Phase transition
    always_comb
    begin
        unique case (phase)
            PH_EXPECT_CMD, PH_AFTER_SEP, PH_EXPECT_TGT:
            begin
                if (is_blank)
                    nxt = phase;
                else if (is_word)
                    nxt = PH_IN_CMD;
                else
                    nxt = PH_REJECTED;
            end
            PH_IN_CMD:
            begin
                if (is_blank || is_word)
                    nxt = PH_IN_CMD;
                else if (ch == CH_PIPE)
                    nxt = PH_EXPECT_CMD;
                else if (ch == CH_AMP || ch == CH_SEMI)
                    nxt = PH_AFTER_SEP;
                else if (ch == CH_LT)
                    nxt = PH_EXPECT_TGT;
                else if (ch == CH_GT)
                    nxt = PH_AFTER_GT;
                else
                    nxt = PH_REJECTED;
            end
            PH_AFTER_GT:
            begin
                // only an adjacent second '>' appends
                if (ch == CH_GT || is_blank)
                    nxt = PH_EXPECT_TGT;
                else if (is_word)
                    nxt = PH_IN_CMD;
                else
                    nxt = PH_REJECTED;
            end
            default: nxt = PH_REJECTED;
        endcase
    end

    // A terminator gives the verdict and restarts the line
    always_comb
    begin
        step.is_end     = line_end || (ch == CH_NUL);
        step.ok         = (phase == PH_IN_CMD) || (phase == PH_AFTER_SEP);
        step.next_phase = step.is_end ? PH_EXPECT_CMD : nxt;
    end

endmodule
`default_nettype wire
